// ===== rtl/stt_pkg.sv =====
// Shared types, constants and character classes of the source text tokenizer.
package stt_pkg;

  localparam int OFFSET_BITS_DEF   = 24;
  localparam int LINE_BITS_DEF     = 20;
  localparam int KEYWORD_BYTES_DEF = 6;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int START_W = 24;
  localparam int LEN_W   = 24;
  localparam int LINE_W  = 20;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [3:0] {
    TK_IDENT     = 4'd0,
    TK_KEYWORD   = 4'd1,
    TK_STRING    = 4'd2,
    TK_NUMBER    = 4'd3,
    TK_COLON     = 4'd4,
    TK_LPAREN    = 4'd5,
    TK_RPAREN    = 4'd6,
    TK_LBRACE    = 4'd7,
    TK_RBRACE    = 4'd8,
    TK_PLUS      = 4'd9,
    TK_COMMA     = 4'd10,
    TK_SEMICOLON = 4'd11,
    TK_ARROW     = 4'd12,
    TK_UNKNOWN   = 4'd13,
    TK_END       = 4'd14,
    TK_UNTERM    = 4'd15
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_NUM   = 3'd2,
    MODE_STR   = 3'd3,
    MODE_MINUS = 3'd4
  } scan_mode_t;

  localparam logic [3:0] KW_NONE = 4'd9;
  localparam int         KW_COUNT = 9;

  // Keyword text, first character in the low byte
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h000000636E66,  // fnc
    48'h00000074656C,  // let
    48'h000000726176,  // var
    48'h6E7275746572,  // return
    48'h000000676F6C,  // log
    48'h006E6C676F6C,  // logln
    48'h0000706F6F6C,  // loop
    48'h676E69727473,  // string
    48'h000000746E69   // int
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd3, 3'd3, 3'd6, 3'd3, 3'd5, 3'd4, 3'd6, 3'd3
  };

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef struct packed {
    tok_kind_t           kind;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    length;
    logic [3:0]          kw;
    logic [LINE_W-1:0]   line;
  } token_t;

  // All tokens caused by one word of input, in order
  typedef struct packed {
    token_t [2:0] tok;
    logic [1:0]   cnt;
  } group_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic tok_kind_t punct_kind(input logic [7:0] c);
    tok_kind_t k;
    unique case (c)
      ":":     k = TK_COLON;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "+":     k = TK_PLUS;
      ",":     k = TK_COMMA;
      ";":     k = TK_SEMICOLON;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/stt_fifo.sv =====
// Small register queue carrying token groups from the scanner to the output stage.
module stt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = count != FULL_CNT;
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/stt_front.sv =====
// Scanner: takes one byte a cycle while the queue has room, tracks tokens, builds groups.
module stt_front #(
  parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS     = stt_pkg::LINE_BITS_DEF,
  parameter int KEYWORD_BYTES = stt_pkg::KEYWORD_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      text_byte,
  input  logic            final_byte,
  output logic            push_valid,
  input  logic            push_ready,
  output stt_pkg::group_t push_data
);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
  localparam logic [LINE_BITS-1:0]   LINE_FIRST = LINE_BITS'(1);

  stt_pkg::scan_mode_t                mode, mode_next;
  logic [OFFSET_BITS-1:0]             offset, offset_next;
  logic [LINE_BITS-1:0]               line, line_next;
  logic [OFFSET_BITS-1:0]             pstart, pstart_next;
  logic [stt_pkg::LEN_W-1:0]          plen, plen_next;
  logic [KEYWORD_BYTES-1:0][7:0]      wbuf, wbuf_ext, wbuf_next;
  logic [stt_pkg::LEN_W-1:0]          plen_ext;
  logic [3:0]                         kw_ext;
  logic                               accept;
  logic                               cont_word;
  logic                               start_new;
  logic                               nz;
  stt_pkg::token_t                    tk [3];
  logic [1:0]                         n;

  function automatic logic [3:0] kw_match(input logic [KEYWORD_BYTES-1:0][7:0] b,
                                          input logic [stt_pkg::LEN_W-1:0] len);
    logic [3:0] r;
    logic       hit;
    r = stt_pkg::KW_NONE;
    for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
      hit = len == stt_pkg::LEN_W'(stt_pkg::KW_LEN[i]);
      for (int j = 0; j < 6; j++) begin
        if (j < int'(stt_pkg::KW_LEN[i]) && b[j] != stt_pkg::KW_TEXT[i][8*j +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

  function automatic stt_pkg::token_t mk_tok(input stt_pkg::tok_kind_t kind,
                                             input logic [OFFSET_BITS-1:0] start,
                                             input logic [stt_pkg::LEN_W-1:0] len,
                                             input logic [3:0] kw,
                                             input logic [LINE_BITS-1:0] ln);
    stt_pkg::token_t t;
    t.kind   = kind;
    t.start  = stt_pkg::START_W'(start);
    t.length = len;
    t.kw     = kw;
    t.line   = stt_pkg::LINE_W'(ln);
    return t;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = push_ready;
  assign nz       = text_byte != stt_pkg::CH_NUL;

  // Word buffer and length as they stand once a continuing word byte is taken
  always_comb begin
    cont_word = accept && nz && mode == stt_pkg::MODE_WORD &&
                (stt_pkg::is_alpha(text_byte) || stt_pkg::is_digit(text_byte));
    wbuf_ext  = wbuf;
    plen_ext  = plen;
    if (cont_word) begin
      for (int j = 0; j < KEYWORD_BYTES; j++) begin
        if (plen == stt_pkg::LEN_W'(j)) begin
          wbuf_ext[j] = text_byte;
        end
      end
      if (plen != stt_pkg::LEN_MAX) begin
        plen_ext = plen + 1'b1;
      end
    end
    kw_ext = kw_match(wbuf_ext, plen_ext);
  end

  always_comb begin
    mode_next   = mode;
    offset_next = offset;
    line_next   = line;
    pstart_next = pstart;
    plen_next   = plen_ext;
    wbuf_next   = wbuf_ext;
    start_new   = 1'b0;
    n           = 2'd0;
    for (int i = 0; i < 3; i++) begin
      tk[i] = '0;
    end

    if (accept) begin
      if (nz) begin
        unique case (mode)
          stt_pkg::MODE_STR: begin
            if (text_byte == stt_pkg::CH_QUOTE) begin
              tk[n] = mk_tok(stt_pkg::TK_STRING, pstart, plen, stt_pkg::KW_NONE, line);
              n = n + 1'b1;
              mode_next = stt_pkg::MODE_IDLE;
            end else begin
              if (plen != stt_pkg::LEN_MAX) begin
                plen_next = plen + 1'b1;
              end
              if (text_byte == stt_pkg::CH_NEWLINE && line != LINE_MAX) begin
                line_next = line + 1'b1;
              end
            end
          end
          stt_pkg::MODE_WORD: begin
            if (!cont_word) begin
              tk[n] = mk_tok((kw_ext == stt_pkg::KW_NONE) ? stt_pkg::TK_IDENT
                                                          : stt_pkg::TK_KEYWORD,
                             pstart, plen, kw_ext, line);
              n = n + 1'b1;
              start_new = 1'b1;
            end
          end
          stt_pkg::MODE_NUM: begin
            if (stt_pkg::is_digit(text_byte)) begin
              if (plen != stt_pkg::LEN_MAX) begin
                plen_next = plen + 1'b1;
              end
            end else begin
              tk[n] = mk_tok(stt_pkg::TK_NUMBER, pstart, plen, stt_pkg::KW_NONE, line);
              n = n + 1'b1;
              start_new = 1'b1;
            end
          end
          stt_pkg::MODE_MINUS: begin
            if (text_byte == stt_pkg::CH_GT) begin
              tk[n] = mk_tok(stt_pkg::TK_ARROW, pstart, stt_pkg::LEN_W'(2),
                             stt_pkg::KW_NONE, line);
              n = n + 1'b1;
              mode_next = stt_pkg::MODE_IDLE;
            end else begin
              tk[n] = mk_tok(stt_pkg::TK_UNKNOWN, pstart, stt_pkg::LEN_W'(1),
                             stt_pkg::KW_NONE, line);
              n = n + 1'b1;
              start_new = 1'b1;
            end
          end
          default: start_new = 1'b1;
        endcase

        // Classify the byte as the first of a new token
        if (start_new) begin
          mode_next = stt_pkg::MODE_IDLE;
          if (stt_pkg::is_space(text_byte)) begin
            if (text_byte == stt_pkg::CH_NEWLINE && line != LINE_MAX) begin
              line_next = line + 1'b1;
            end
          end else if (stt_pkg::is_alpha(text_byte)) begin
            mode_next    = stt_pkg::MODE_WORD;
            pstart_next  = offset;
            plen_next    = stt_pkg::LEN_W'(1);
            wbuf_next[0] = text_byte;
          end else if (stt_pkg::is_digit(text_byte)) begin
            mode_next   = stt_pkg::MODE_NUM;
            pstart_next = offset;
            plen_next   = stt_pkg::LEN_W'(1);
          end else if (text_byte == stt_pkg::CH_QUOTE) begin
            mode_next   = stt_pkg::MODE_STR;
            pstart_next = (offset != OFFSET_MAX) ? offset + 1'b1 : offset;
            plen_next   = '0;
          end else if (text_byte == stt_pkg::CH_MINUS) begin
            mode_next   = stt_pkg::MODE_MINUS;
            pstart_next = offset;
            plen_next   = stt_pkg::LEN_W'(1);
          end else begin
            tk[n] = mk_tok(stt_pkg::punct_kind(text_byte), offset, stt_pkg::LEN_W'(1),
                           stt_pkg::KW_NONE, line);
            n = n + 1'b1;
          end
        end

        if (offset != OFFSET_MAX) begin
          offset_next = offset + 1'b1;
        end
      end

      // End of text: flush what is pending, then return to the reset state
      if (!nz || final_byte) begin
        if (mode_next == stt_pkg::MODE_STR) begin
          tk[n] = mk_tok(stt_pkg::TK_UNTERM, pstart_next, plen_next, stt_pkg::KW_NONE,
                         line_next);
          n = n + 1'b1;
        end else begin
          if (mode_next == stt_pkg::MODE_WORD) begin
            // a word begun by this very byte has length one and is no keyword
            tk[n] = mk_tok((start_new || kw_ext == stt_pkg::KW_NONE) ? stt_pkg::TK_IDENT
                                                                     : stt_pkg::TK_KEYWORD,
                           pstart_next, plen_next,
                           start_new ? stt_pkg::KW_NONE : kw_ext, line_next);
            n = n + 1'b1;
          end else if (mode_next == stt_pkg::MODE_NUM) begin
            tk[n] = mk_tok(stt_pkg::TK_NUMBER, pstart_next, plen_next, stt_pkg::KW_NONE,
                           line_next);
            n = n + 1'b1;
          end else if (mode_next == stt_pkg::MODE_MINUS) begin
            tk[n] = mk_tok(stt_pkg::TK_UNKNOWN, pstart_next, stt_pkg::LEN_W'(1),
                           stt_pkg::KW_NONE, line_next);
            n = n + 1'b1;
          end
          tk[n] = mk_tok(stt_pkg::TK_END, offset_next, '0, stt_pkg::KW_NONE, line_next);
          n = n + 1'b1;
        end
        mode_next   = stt_pkg::MODE_IDLE;
        offset_next = '0;
        line_next   = LINE_FIRST;
        pstart_next = '0;
        plen_next   = '0;
      end
    end

    push_valid = accept && n != 2'd0;
    for (int i = 0; i < 3; i++) begin
      push_data.tok[i] = tk[i];
    end
    push_data.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= stt_pkg::MODE_IDLE;
      offset <= '0;
      line   <= LINE_FIRST;
      pstart <= '0;
      plen   <= '0;
    end else begin
      mode   <= mode_next;
      offset <= offset_next;
      line   <= line_next;
      pstart <= pstart_next;
      plen   <= plen_next;
    end
  end

  always_ff @(posedge clk) begin
    wbuf <= wbuf_next;
  end

endmodule

// ===== rtl/stt_back.sv =====
// Output stage: unpacks groups, registers one token a cycle out while out_ready is high.
module stt_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  stt_pkg::group_t              pop_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3:0]                   token_kind,
  output logic [stt_pkg::START_W-1:0]  token_start,
  output logic [stt_pkg::LEN_W-1:0]    token_length,
  output logic [3:0]                   keyword_code,
  output logic [stt_pkg::LINE_W-1:0]   line_number,
  output logic                         run_last
);

  logic [1:0]      sel;
  logic            load;
  logic            last;
  stt_pkg::token_t cur;

  assign load      = pop_valid && (!out_valid || out_ready);
  assign cur       = pop_data.tok[sel];
  assign last      = sel == 2'(pop_data.cnt - 2'd1);
  // release the group once its final token is loaded
  assign pop_ready = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= last ? 2'd0 : sel + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= cur.kind;
      token_start  <= cur.start;
      token_length <= cur.length;
      keyword_code <= cur.kw;
      line_number  <= cur.line;
      run_last     <= last;
    end
  end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: scanner, token queue and output stage.
// A byte is taken in every cycle in which in_ready is high; in_ready drops only when
// the token queue (QUEUE_DEPTH groups, one group per byte that yields tokens) is full.
// Tokens leave through a registered output at one per cycle while out_ready is high, so
// a byte that yields several tokens (up to three: a closed token, a mark and the end
// token) holds the output stage until all are handed on; bytes yielding one token or
// none stream at one byte a cycle while out_ready is high. When nothing waits, the first
// token of a byte goes into the token queue and is then loaded into the output register.
module source_text_tokenizer #(
  parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS     = stt_pkg::LINE_BITS_DEF,
  parameter int KEYWORD_BYTES = stt_pkg::KEYWORD_BYTES_DEF,
  parameter int QUEUE_DEPTH   = stt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   text_byte,
  input  logic                         final_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3:0]                   token_kind,
  output logic [stt_pkg::START_W-1:0]  token_start,
  output logic [stt_pkg::LEN_W-1:0]    token_length,
  output logic [3:0]                   keyword_code,
  output logic [stt_pkg::LINE_W-1:0]   line_number,
  output logic                         run_last
);

  localparam int GW = $bits(stt_pkg::group_t);

  logic            push_valid;
  logic            push_ready;
  stt_pkg::group_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  logic [GW-1:0]   pop_bits;

  stt_front #(
    .OFFSET_BITS   (OFFSET_BITS),
    .LINE_BITS     (LINE_BITS),
    .KEYWORD_BYTES (KEYWORD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  stt_fifo #(
    .WIDTH (GW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_bits)
  );

  stt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (stt_pkg::group_t'(pop_bits)),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .keyword_code (keyword_code),
    .line_number  (line_number),
    .run_last     (run_last)
  );

endmodule

// ===== rtl/stt_checker.sv =====
// Port-level checks on the tokenizer, attached to the top level by bind.
module stt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [3:0]                   token_kind,
  input logic [stt_pkg::START_W-1:0]  token_start,
  input logic [stt_pkg::LEN_W-1:0]    token_length,
  input logic [3:0]                   keyword_code,
  input logic                         run_last
);

  // Hold a stalled word steady
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
    $stable(token_start) && $stable(token_length))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // End and open-string tokens close the run of their byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == stt_pkg::TK_END || token_kind == stt_pkg::TK_UNTERM)
    |-> run_last)
    else $error("end token not marked last");

  a_kw_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((token_kind == stt_pkg::TK_KEYWORD) == (keyword_code != stt_pkg::KW_NONE)))
    else $error("keyword code disagrees with token kind");

  a_arrow_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == stt_pkg::TK_ARROW |-> token_length == stt_pkg::LEN_W'(2))
    else $error("arrow length wrong");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

// ===== tb/tb_source_text_tokenizer.sv =====
// Self-checking testbench for the source text tokenizer: byte stimulus, token predictor, checker.
`timescale 1ns / 100ps

module tb_source_text_tokenizer;

  localparam int KW_BYTES = stt_pkg::KEYWORD_BYTES_DEF;
  localparam int KW_IW    = $clog2(KW_BYTES);

  typedef struct {
    logic [7:0] b;
    logic       fin;
  } src_word_t;

  typedef struct {
    stt_pkg::tok_kind_t          kind;
    logic [stt_pkg::START_W-1:0] start;
    logic [stt_pkg::LEN_W-1:0]   len;
    logic [3:0]                  kw;
    logic [stt_pkg::LINE_W-1:0]  line;
    logic                        last;
  } token_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] text_byte = 8'd0;
  logic final_byte = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, run_last;
  logic [3:0] token_kind, keyword_code;
  logic [stt_pkg::START_W-1:0] token_start;
  logic [stt_pkg::LEN_W-1:0] token_length;
  logic [stt_pkg::LINE_W-1:0] line_number;

  source_text_tokenizer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .keyword_code (keyword_code),
    .line_number  (line_number),
    .run_last     (run_last)
  );

  src_word_t  src_words [$];
  token_rec_t tokens_due [$];
  logic [7:0] txt [$];
  int         errors = 0;
  int         cyc = 0;
  logic       in_fire = 1'b0;
  token_rec_t seen_tok;

  // Stretch of cycles with no idling on either side
  wire calm = (cyc >= 40) && (cyc < 140);

  string kw_word [stt_pkg::KW_COUNT] = '{"fnc", "let", "var", "return", "log", "logln",
                                         "loop", "string", "int"};

  // Scanner state as the predictor sees it
  stt_pkg::scan_mode_t         mode;
  logic [stt_pkg::START_W-1:0] cur_offset;
  logic [stt_pkg::LINE_W-1:0]  cur_line;
  logic [stt_pkg::START_W-1:0] tok_start;
  logic [stt_pkg::LEN_W-1:0]   tok_len;
  logic [7:0]                  word_buf [KW_BYTES];
  token_rec_t                  held;
  logic                        have_held;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic blank_byte(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  task automatic clear_scan();
    mode       = stt_pkg::MODE_IDLE;
    cur_offset = '0;
    cur_line   = stt_pkg::LINE_W'(1);
    tok_start  = '0;
    tok_len    = '0;
  endtask

  // Hold the newest token back so the last one of a word can be flagged
  task automatic add_token(input stt_pkg::tok_kind_t k, input logic [stt_pkg::START_W-1:0] s,
                           input logic [stt_pkg::LEN_W-1:0] n, input logic [3:0] kw);
    if (have_held) tokens_due.insert(tokens_due.size(), held);
    held.kind  = k;
    held.start = s;
    held.len   = n;
    held.kw    = kw;
    held.line  = cur_line;
    held.last  = 1'b0;
    have_held  = 1'b1;
  endtask

  function automatic logic [3:0] keyword_of();
    logic hit;
    if (tok_len > KW_BYTES) return stt_pkg::KW_NONE;
    for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
      if (kw_word[i].len() == tok_len) begin
        hit = 1'b1;
        for (int j = 0; j < kw_word[i].len(); j++)
          if (kw_word[i][j] != word_buf[j]) hit = 1'b0;
        if (hit) return 4'(i);
      end
    end
    return stt_pkg::KW_NONE;
  endfunction

  task automatic grow_len();
    if (tok_len != '1) tok_len++;
  endtask

  task automatic count_line();
    if (cur_line != '1) cur_line++;
  endtask

  // Emit the token still open in word, number or minus mode
  task automatic close_open_token();
    logic [3:0] kw;
    if (mode == stt_pkg::MODE_WORD) begin
      kw = keyword_of();
      add_token(kw == stt_pkg::KW_NONE ? stt_pkg::TK_IDENT : stt_pkg::TK_KEYWORD,
                tok_start, tok_len, kw);
    end else if (mode == stt_pkg::MODE_NUM) begin
      add_token(stt_pkg::TK_NUMBER, tok_start, tok_len, stt_pkg::KW_NONE);
    end else if (mode == stt_pkg::MODE_MINUS) begin
      add_token(stt_pkg::TK_UNKNOWN, tok_start, stt_pkg::LEN_W'(1), stt_pkg::KW_NONE);
    end
    mode = stt_pkg::MODE_IDLE;
  endtask

  task automatic scan_char(input logic [7:0] c);
    logic [stt_pkg::START_W-1:0] here;
    logic                        taken;
    stt_pkg::tok_kind_t          k;
    here  = cur_offset;
    taken = 1'b0;
    if (mode == stt_pkg::MODE_STR) begin
      taken = 1'b1;
      if (c == stt_pkg::CH_QUOTE) begin
        add_token(stt_pkg::TK_STRING, tok_start, tok_len, stt_pkg::KW_NONE);
        mode = stt_pkg::MODE_IDLE;
      end else begin
        grow_len();
        if (c == stt_pkg::CH_NEWLINE) count_line();
      end
    end else if (mode == stt_pkg::MODE_WORD) begin
      if (letter_byte(c) || digit_byte(c)) begin
        if (tok_len < KW_BYTES) word_buf[tok_len[KW_IW-1:0]] = c;
        grow_len();
        taken = 1'b1;
      end else begin
        close_open_token();
      end
    end else if (mode == stt_pkg::MODE_NUM) begin
      if (digit_byte(c)) begin
        grow_len();
        taken = 1'b1;
      end else begin
        close_open_token();
      end
    end else if (mode == stt_pkg::MODE_MINUS) begin
      if (c == stt_pkg::CH_GT) begin
        add_token(stt_pkg::TK_ARROW, tok_start, stt_pkg::LEN_W'(2), stt_pkg::KW_NONE);
        mode  = stt_pkg::MODE_IDLE;
        taken = 1'b1;
      end else begin
        close_open_token();
      end
    end
    if (!taken) begin
      mode = stt_pkg::MODE_IDLE;
      if (blank_byte(c)) begin
        if (c == stt_pkg::CH_NEWLINE) count_line();
      end else if (letter_byte(c)) begin
        mode        = stt_pkg::MODE_WORD;
        tok_start   = here;
        tok_len     = stt_pkg::LEN_W'(1);
        word_buf[0] = c;
      end else if (digit_byte(c)) begin
        mode      = stt_pkg::MODE_NUM;
        tok_start = here;
        tok_len   = stt_pkg::LEN_W'(1);
      end else if (c == stt_pkg::CH_QUOTE) begin
        mode      = stt_pkg::MODE_STR;
        tok_start = (here != '1) ? here + 1'b1 : here;
        tok_len   = '0;
      end else if (c == stt_pkg::CH_MINUS) begin
        mode      = stt_pkg::MODE_MINUS;
        tok_start = here;
        tok_len   = stt_pkg::LEN_W'(1);
      end else begin
        unique case (c)
          ":":     k = stt_pkg::TK_COLON;
          "(":     k = stt_pkg::TK_LPAREN;
          ")":     k = stt_pkg::TK_RPAREN;
          "{":     k = stt_pkg::TK_LBRACE;
          "}":     k = stt_pkg::TK_RBRACE;
          "+":     k = stt_pkg::TK_PLUS;
          ",":     k = stt_pkg::TK_COMMA;
          ";":     k = stt_pkg::TK_SEMICOLON;
          default: k = stt_pkg::TK_UNKNOWN;
        endcase
        add_token(k, here, stt_pkg::LEN_W'(1), stt_pkg::KW_NONE);
      end
    end
  endtask

  // Work out every token that one accepted word of text causes
  task automatic tokenize_byte(input logic [7:0] c, input logic fin);
    have_held = 1'b0;
    if (c != stt_pkg::CH_NUL) begin
      scan_char(c);
      if (cur_offset != '1) cur_offset++;
    end
    if (c == stt_pkg::CH_NUL || fin) begin
      if (mode == stt_pkg::MODE_STR) begin
        add_token(stt_pkg::TK_UNTERM, tok_start, tok_len, stt_pkg::KW_NONE);
      end else begin
        close_open_token();
        add_token(stt_pkg::TK_END, cur_offset, '0, stt_pkg::KW_NONE);
      end
      clear_scan();
    end
    if (have_held) begin
      held.last = 1'b1;
      tokens_due.insert(tokens_due.size(), held);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic add_text(input logic [7:0] c);
    txt.insert(txt.size(), c);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) add_text(s[i]);
  endtask

  // Move the text being built into the stimulus queue, flagging its last word if asked
  task automatic flush_text(input logic fin);
    src_word_t w;
    for (int i = 0; i < txt.size(); i++) begin
      w.b   = txt[i];
      w.fin = fin && (i == txt.size() - 1);
      src_words.insert(src_words.size(), w);
    end
    txt.delete();
  endtask

  task automatic push_random_chars(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 9) == 0 ? stt_pkg::CH_NEWLINE : 8'($urandom_range(32, 126));
      add_text(c == stt_pkg::CH_QUOTE ? 8'h78 : c);
    end
  endtask

  task automatic gen_piece();
    int    r, n;
    string marks;
    marks = ":(){}+,;";
    r = $urandom_range(0, 99);
    if (r < 15) begin
      push_str(kw_word[$urandom_range(0, stt_pkg::KW_COUNT - 1)]);
    end else if (r < 30) begin
      n = $urandom_range(1, 9);
      add_text($urandom_range(0, 4) == 0 ? 8'h5F : 8'($urandom_range(97, 122)));
      for (int i = 1; i < n; i++)
        case ($urandom_range(0, 3))
          0:       add_text(8'($urandom_range(48, 57)));
          1:       add_text(8'($urandom_range(65, 90)));
          default: add_text(8'($urandom_range(97, 122)));
        endcase
    end else if (r < 42) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) add_text(8'($urandom_range(48, 57)));
    end else if (r < 52) begin
      add_text(stt_pkg::CH_QUOTE);
      push_random_chars($urandom_range(0, 5));
      add_text(stt_pkg::CH_QUOTE);
    end else if (r < 62) begin
      add_text(marks[$urandom_range(0, 7)]);
    end else if (r < 68) begin
      push_str("->");
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       add_text(8'h09);
        1:       add_text(stt_pkg::CH_NEWLINE);
        2:       add_text(8'h0D);
        default: add_text(8'h20);
      endcase
    end else if (r < 88) begin
      add_text(stt_pkg::CH_MINUS);
    end else begin
      add_text(8'($urandom_range(1, 255)));
    end
  endtask

  // Source side: offer the next word once the previous one has gone
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (src_words.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        in_valid   <= 1'b1;
        text_byte  <= src_words[0].b;
        final_byte <= src_words[0].fin;
        src_words.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && (calm || $urandom_range(0, 99) >= 9);
  end

  // Predict on each accepted word, check each accepted token against the oldest due
  always @(posedge clk) begin
    cyc     <= cyc + 1;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) tokenize_byte(text_byte, final_byte);
    if (!rst && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        $error("token_kind: expected none, actual %0d", token_kind);
        errors++;
      end else begin
        seen_tok = tokens_due.pop_front();
        check_field("token_kind", seen_tok.kind, token_kind);
        check_field("token_start", seen_tok.start, token_start);
        check_field("token_length", seen_tok.len, token_length);
        check_field("keyword_code", seen_tok.kw, keyword_code);
        check_field("line_number", seen_tok.line, line_number);
        check_field("run_last", seen_tok.last, run_last);
      end
    end
  end

  initial begin
    int made;
    clear_scan();
    have_held = 1'b0;
    for (int i = 0; i < KW_BYTES; i++) word_buf[i] = '0;

    // Marks, arrow, lone minus, string across a newline, high byte, number closed by the end
    push_str("logln(\"a\nb\")->-+,;{}:");
    add_text(8'hFF);
    push_str(" 42");
    flush_text(1'b1);
    // Open string ended by a zero word
    push_str("\"ab");
    add_text(stt_pkg::CH_NUL);
    flush_text(1'b0);
    // Empty text: zero word that is also flagged final
    add_text(stt_pkg::CH_NUL);
    flush_text(1'b1);
    // Seven-letter word is no keyword; high byte flagged final
    push_str("strings");
    add_text(8'h80);
    flush_text(1'b1);
    push_str("-");
    flush_text(1'b1);
    push_str("int var");
    flush_text(1'b1);

    made = src_words.size();
    while (made < 110) begin
      repeat ($urandom_range(1, 8)) begin
        gen_piece();
        if ($urandom_range(0, 1) == 0) add_text(8'h20);
      end
      if ($urandom_range(0, 99) < 20) begin
        add_text(stt_pkg::CH_QUOTE);
        push_random_chars($urandom_range(0, 4));
      end
      if ($urandom_range(0, 1) == 0) begin
        made += txt.size();
        flush_text(1'b1);
      end else begin
        add_text(stt_pkg::CH_NUL);
        made += txt.size();
        flush_text(1'($urandom_range(0, 1)));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (src_words.size() != 0 || in_valid) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("source_text_tokenizer regression: pass");
    else
      $display("source_text_tokenizer regression: fail");
    $finish;
  end

  initial begin
    #400000;
    $display("source_text_tokenizer regression: fail");
    $finish;
  end

endmodule
